FILE: sv/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

	localparam int unsigned MaxResults = 4;

	localparam logic [7:0] CharQuote     = 8'h22;
	localparam logic [7:0] CharBackslash = 8'h5C;
	localparam logic [7:0] CharU         = 8'h75;
	localparam logic [7:0] CharB         = 8'h62;
	localparam logic [7:0] CharF         = 8'h66;
	localparam logic [7:0] CharN         = 8'h6E;
	localparam logic [7:0] CharR         = 8'h72;
	localparam logic [7:0] CharT         = 8'h74;

	localparam logic [15:0] Utf8Max1 = 16'h007F;
	localparam logic [15:0] Utf8Max2 = 16'h07FF;
	localparam logic [7:0]  Utf8Lead2 = 8'hC0;
	localparam logic [7:0]  Utf8Lead3 = 8'hE0;
	localparam logic [7:0]  Utf8Cont  = 8'h80;
	localparam logic [7:0]  Utf8Mask6 = 8'h3F;

	typedef enum logic [2:0] {
		ST_DATA     = 3'd0,
		ST_DONE     = 3'd1,
		ST_NO_QUOTE = 3'd2,
		ST_BAD_HEX  = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_STRING = 2'd1,
		MODE_ESCAPE = 2'd2,
		MODE_HEX    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       eot;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] data;
	} result_t;

	typedef struct packed {
		result_t [MaxResults-1:0] entry;
		logic [2:0]               count;
	} run_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [7:0] escape_char(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CharB: r = 8'h08;
			CharF: r = 8'h0C;
			CharN: r = 8'h0A;
			CharR: r = 8'h0D;
			CharT: r = 8'h09;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/json_string_unescaper.sv
// Top level of the JSON string unescaper.
// Text bytes arrive on the text channel (text_valid / text_stall) with the
// start_of_string and end_of_text flags; decoded results leave on the result
// channel (result_valid / result_stall) as status, out_byte and last_of_run.
// A request is taken at a clock edge where valid is high and stall is low.
// Each text byte yields zero to four results; last_of_run marks the final one.
// The first result of a byte is shown from the result register once the byte
// has passed the input register and been decoded into a run. Throughput: one
// text byte per cycle while each byte yields at most one result and the
// receiver does not stall; a byte with more results holds the single result
// register until all have left, since it sends one result per cycle.
// The input side has a two-entry buffer, so text_stall is a registered flag
// that rises only once both entries are full.
// When the receiver stalls, the shown result holds unchanged and the input
// buffer fills, then text_stall rises.
// Reset (arst_n low) empties both buffers and returns the parser to idle, with
// no string open.
module json_string_unescaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       start_of_string,
	input  logic       end_of_text,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] status,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	jsu_pkg::in_item_t in_item;
	jsu_pkg::in_item_t s1_item;
	jsu_pkg::run_t     run;
	logic              s1_valid;
	logic              take;

	assign in_item = '{text_byte, start_of_string, end_of_text};

	jsu_input_buf u_input_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.in_item    (in_item),
		.take       (take),
		.s1_valid   (s1_valid),
		.s1_item    (s1_item)
	);

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1_item (s1_item),
		.take    (take),
		.run     (run)
	);

	jsu_result_reg u_result_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.run          (run),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

endmodule

FILE: sv/jsu_input_buf.sv
// Input register with skid entry: takes a request every cycle while stall is low; stall is registered.
module jsu_input_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_stall,
	input  jsu_pkg::in_item_t  in_item,
	input  logic               take,
	output logic               s1_valid,
	output jsu_pkg::in_item_t  s1_item
);

	logic              s1_valid_q;
	logic              skid_valid_q;
	jsu_pkg::in_item_t s1_item_q;
	jsu_pkg::in_item_t skid_item_q;
	logic              accept;
	logic              s1_free;

	assign text_stall = skid_valid_q;
	assign accept     = text_valid & ~skid_valid_q;
	assign s1_free    = ~s1_valid_q | take;
	assign s1_valid   = s1_valid_q;
	assign s1_item    = s1_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (s1_free) begin
			if (skid_valid_q) begin
				s1_valid_q   <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				s1_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			if (skid_valid_q) begin
				s1_item_q <= skid_item_q;
			end else if (accept) begin
				s1_item_q <= in_item;
			end
		end else if (accept) begin
			// hold the request that cannot move yet
			skid_item_q <= in_item;
		end
	end

endmodule

FILE: sv/jsu_decode.sv
// Parser state and the single-pass decode of one text byte into a run of results.
module jsu_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::in_item_t s1_item,
	input  logic              take,
	output jsu_pkg::run_t     run
);

	jsu_pkg::mode_t mode_q, mode_n;
	logic [1:0]     hex_cnt_q, hex_cnt_n;
	logic [15:0]    acc_q, acc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= jsu_pkg::MODE_IDLE;
			hex_cnt_q <= 2'd0;
			acc_q     <= 16'd0;
		end else if (take) begin
			mode_q    <= mode_n;
			hex_cnt_q <= hex_cnt_n;
			acc_q     <= acc_n;
		end
	end

	always_comb begin
		logic [7:0]  c;
		logic [4:0]  nib;
		logic [15:0] cp;
		logic [2:0]  n;
		jsu_pkg::result_t [jsu_pkg::MaxResults-1:0] res;

		c   = s1_item.data;
		nib = jsu_pkg::hex_nibble(c);
		cp  = {acc_q[11:0], nib[3:0]};
		n   = 3'd0;
		res = '0;
		mode_n    = mode_q;
		hex_cnt_n = hex_cnt_q;
		acc_n     = acc_q;

		if (s1_item.start) begin
			hex_cnt_n = 2'd0;
			acc_n     = 16'd0;
			if (c != jsu_pkg::CharQuote) begin
				mode_n = jsu_pkg::MODE_IDLE;
				res[n[1:0]] = '{jsu_pkg::ST_NO_QUOTE, 8'd0};
				n = n + 3'd1;
			end else begin
				mode_n = jsu_pkg::MODE_STRING;
			end
		end else begin
			case (mode_q)
				jsu_pkg::MODE_STRING: begin
					if (c == jsu_pkg::CharQuote) begin
						mode_n = jsu_pkg::MODE_IDLE;
						res[n[1:0]] = '{jsu_pkg::ST_DONE, 8'd0};
						n = n + 3'd1;
					end else if (c == jsu_pkg::CharBackslash) begin
						mode_n = jsu_pkg::MODE_ESCAPE;
					end else begin
						res[n[1:0]] = '{jsu_pkg::ST_DATA, c};
						n = n + 3'd1;
					end
				end
				jsu_pkg::MODE_ESCAPE: begin
					if (c == jsu_pkg::CharU) begin
						mode_n    = jsu_pkg::MODE_HEX;
						hex_cnt_n = 2'd0;
						acc_n     = 16'd0;
					end else begin
						mode_n = jsu_pkg::MODE_STRING;
						res[n[1:0]] = '{jsu_pkg::ST_DATA, jsu_pkg::escape_char(c)};
						n = n + 3'd1;
					end
				end
				jsu_pkg::MODE_HEX: begin
					if (!nib[4]) begin
						mode_n = jsu_pkg::MODE_IDLE;
						res[n[1:0]] = '{jsu_pkg::ST_BAD_HEX, 8'd0};
						n = n + 3'd1;
					end else begin
						acc_n = cp;
						if (hex_cnt_q == 2'd3) begin
							hex_cnt_n = 2'd0;
							mode_n    = jsu_pkg::MODE_STRING;
							// emit the code point as UTF-8
							if (cp <= jsu_pkg::Utf8Max1) begin
								res[0] = '{jsu_pkg::ST_DATA, cp[7:0]};
								n = 3'd1;
							end else if (cp <= jsu_pkg::Utf8Max2) begin
								res[0] = '{jsu_pkg::ST_DATA,
									jsu_pkg::Utf8Lead2 | {3'd0, cp[10:6]}};
								res[1] = '{jsu_pkg::ST_DATA,
									jsu_pkg::Utf8Cont | {2'd0, cp[5:0]}};
								n = 3'd2;
							end else begin
								res[0] = '{jsu_pkg::ST_DATA,
									jsu_pkg::Utf8Lead3 | {4'd0, cp[15:12]}};
								res[1] = '{jsu_pkg::ST_DATA,
									jsu_pkg::Utf8Cont | ({2'd0, cp[11:6]} & jsu_pkg::Utf8Mask6)};
								res[2] = '{jsu_pkg::ST_DATA,
									jsu_pkg::Utf8Cont | ({2'd0, cp[5:0]} & jsu_pkg::Utf8Mask6)};
								n = 3'd3;
							end
						end else begin
							hex_cnt_n = hex_cnt_q + 2'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (s1_item.eot && mode_n != jsu_pkg::MODE_IDLE) begin
			mode_n    = jsu_pkg::MODE_IDLE;
			hex_cnt_n = 2'd0;
			res[n[1:0]] = '{jsu_pkg::ST_TRUNC, 8'd0};
			n = n + 3'd1;
		end

		run.entry = res;
		run.count = n;
	end

endmodule

FILE: sv/jsu_result_reg.sv
// Result register holding one run of up to four results, sent one per cycle while the receiver does not stall.
module jsu_result_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s1_valid,
	input  jsu_pkg::run_t run,
	output logic          take,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [2:0]    status,
	output logic [7:0]    out_byte,
	output logic          last_of_run
);

	logic          valid_q;
	logic [1:0]    idx_q;
	jsu_pkg::run_t run_q;
	logic          is_last;
	logic          advance;
	logic          finish;

	assign is_last = ({1'b0, idx_q} + 3'd1) == run_q.count;
	assign advance = valid_q & ~result_stall;
	assign finish  = advance & is_last;
	assign take    = s1_valid & (~valid_q | finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (take) begin
			// a byte that yields nothing leaves the register empty
			valid_q <= run.count != 3'd0;
			idx_q   <= 2'd0;
		end else if (finish) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (advance) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			run_q <= run;
		end
	end

	assign result_valid = valid_q;
	assign status       = run_q.entry[idx_q].status;
	assign out_byte     = run_q.entry[idx_q].data;
	assign last_of_run  = is_last;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the JSON string unescaper: directed escapes and errors plus random text.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import jsu_pkg::*;

	localparam logic [7:0] CharSlash = 8'h2F;
	localparam logic [7:0] Char0     = 8'h30;
	localparam logic [7:0] Char9     = 8'h39;
	localparam logic [7:0] CharLowA  = 8'h61;
	localparam logic [7:0] CharLowF  = 8'h66;
	localparam logic [7:0] CharUpA   = 8'h41;
	localparam logic [7:0] CharUpF   = 8'h46;
	localparam logic [7:0] AsciiBs   = 8'h08;
	localparam logic [7:0] AsciiFf   = 8'h0C;
	localparam logic [7:0] AsciiLf   = 8'h0A;
	localparam logic [7:0] AsciiCr   = 8'h0D;
	localparam logic [7:0] AsciiTab  = 8'h09;

	localparam int HoldCycles    = 300;
	localparam int WatchdogLimit = 2000;
	localparam int DrainSlack    = 6;
	localparam int MaxReports    = 10;

	typedef struct {
		status_t    status;
		logic [7:0] data;
		logic       last;
	} decoded_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       text_valid = 1'b0;
	logic       text_stall;
	logic [7:0] text_byte = 8'h00;
	logic       start_of_string = 1'b0;
	logic       end_of_text = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] out_byte;
	logic       last_of_run;

	json_string_unescaper dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_stall      (text_stall),
		.text_byte       (text_byte),
		.start_of_string (start_of_string),
		.end_of_text     (end_of_text),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.status          (status),
		.out_byte        (out_byte),
		.last_of_run     (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	mode_t       parse_state = MODE_IDLE;
	logic [1:0]  digits_taken = 2'd0;
	logic [15:0] code_point = 16'h0000;

	decoded_result_t expected_output[$];

	int  send_pct = 0;
	int  recv_pct = 0;
	logic hold_go = 1'b0;
	int  bytes_decoded = 0;
	int  results_checked = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	bit  text_cut = 1'b0;
	int  cut_chance = 0;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= Char0 && c <= Char9) begin
			return {1'b1, 4'(c - Char0)};
		end
		if (c >= CharLowA && c <= CharLowF) begin
			return {1'b1, 4'(c - CharLowA + 8'd10)};
		end
		if (c >= CharUpA && c <= CharUpF) begin
			return {1'b1, 4'(c - CharUpA + 8'd10)};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) begin
			return Char0 + 8'(n);
		end
		return (upper ? CharUpA : CharLowA) + 8'(n) - 8'd10;
	endfunction

	task automatic expect_output(input status_t st, input logic [7:0] d);
		decoded_result_t r;
		r.status = st;
		r.data = d;
		r.last = 1'b0;
		expected_output.insert(expected_output.size(), r);
	endtask

	task automatic predict_unescape(input logic [7:0] b, input logic s, input logic e);
		int first;
		logic [4:0] d;
		logic [7:0] m;
		first = expected_output.size();
		if (s || parse_state != MODE_IDLE) begin
			bytes_decoded++;
		end
		if (s) begin
			digits_taken = 2'd0;
			code_point = 16'h0000;
			if (b != CharQuote) begin
				parse_state = MODE_IDLE;
				expect_output(ST_NO_QUOTE, 8'h00);
			end else begin
				parse_state = MODE_STRING;
			end
		end else begin
			case (parse_state)
				MODE_STRING: begin
					if (b == CharQuote) begin
						parse_state = MODE_IDLE;
						expect_output(ST_DONE, 8'h00);
					end else if (b == CharBackslash) begin
						parse_state = MODE_ESCAPE;
					end else begin
						expect_output(ST_DATA, b);
					end
				end
				MODE_ESCAPE: begin
					if (b == CharU) begin
						parse_state = MODE_HEX;
						digits_taken = 2'd0;
						code_point = 16'h0000;
					end else begin
						case (b)
							CharB: m = AsciiBs;
							CharF: m = AsciiFf;
							CharN: m = AsciiLf;
							CharR: m = AsciiCr;
							CharT: m = AsciiTab;
							default: m = b;
						endcase
						parse_state = MODE_STRING;
						expect_output(ST_DATA, m);
					end
				end
				MODE_HEX: begin
					d = hex_digit(b);
					if (!d[4]) begin
						parse_state = MODE_IDLE;
						expect_output(ST_BAD_HEX, 8'h00);
					end else begin
						code_point = {code_point[11:0], d[3:0]};
						if (digits_taken == 2'd3) begin
							digits_taken = 2'd0;
							parse_state = MODE_STRING;
							// emit the code point as one to three UTF-8 bytes
							if (code_point <= Utf8Max1) begin
								expect_output(ST_DATA, code_point[7:0]);
							end else if (code_point <= Utf8Max2) begin
								expect_output(ST_DATA, Utf8Lead2 | 8'(code_point >> 6));
								expect_output(ST_DATA, Utf8Cont | (code_point[7:0] & Utf8Mask6));
							end else begin
								expect_output(ST_DATA, Utf8Lead3 | 8'(code_point >> 12));
								expect_output(ST_DATA, Utf8Cont | (8'(code_point >> 6) & Utf8Mask6));
								expect_output(ST_DATA, Utf8Cont | (code_point[7:0] & Utf8Mask6));
							end
						end else begin
							digits_taken = digits_taken + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
		if (e && parse_state != MODE_IDLE) begin
			parse_state = MODE_IDLE;
			digits_taken = 2'd0;
			expect_output(ST_TRUNC, 8'h00);
		end
		if (expected_output.size() > first) begin
			expected_output[expected_output.size() - 1].last = 1'b1;
		end
	endtask

	// offer one request, hold it until taken, then predict its results
	task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
		while ($urandom_range(99) < send_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		start_of_string <= s;
		end_of_text <= e;
		@(posedge clk);
		while (text_stall) begin
			@(posedge clk);
		end
		predict_unescape(b, s, e);
	endtask

	// drop further bytes of a string once one of them has ended the text
	task automatic put_byte(input logic [7:0] b, input logic s, input bit force_end);
		logic e;
		if (!text_cut) begin
			e = force_end || ($urandom_range(99) < cut_chance);
			send_byte(b, s, e);
			text_cut = e;
		end
	endtask

	task automatic put_token();
		logic [7:0] b;
		logic [15:0] cp;
		int kind;
		kind = $urandom_range(2);
		case (kind)
			0: begin
				do begin
					b = 8'($urandom_range(255));
				end while (b == CharQuote || b == CharBackslash);
				put_byte(b, 1'b0, 1'b0);
			end
			1: begin
				put_byte(CharBackslash, 1'b0, 1'b0);
				case ($urandom_range(8))
					0: b = CharQuote;
					1: b = CharBackslash;
					2: b = CharSlash;
					3: b = CharB;
					4: b = CharF;
					5: b = CharN;
					6: b = CharR;
					7: b = CharT;
					default: begin
						do begin
							b = 8'($urandom_range(255));
						end while (b == CharU);
					end
				endcase
				put_byte(b, 1'b0, 1'b0);
			end
			default: begin
				put_byte(CharBackslash, 1'b0, 1'b0);
				put_byte(CharU, 1'b0, 1'b0);
				case ($urandom_range(2))
					0: cp = 16'($urandom_range(16'h007F));
					1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
					default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
				endcase
				for (int i = 3; i >= 0; i--) begin
					put_byte(hex_char(cp[4*i +: 4], 1'($urandom_range(1))), 1'b0, 1'b0);
				end
			end
		endcase
	endtask

	task automatic send_string(input int cut, input bit close);
		int n;
		text_cut = 1'b0;
		cut_chance = cut;
		put_byte(CharQuote, 1'b1, 1'b0);
		n = $urandom_range(8);
		repeat (n) put_token();
		if (close) begin
			put_byte(CharQuote, 1'b0, $urandom_range(3) == 0);
		end
	endtask

	task automatic send_bad_hex();
		logic [7:0] b;
		logic [4:0] d;
		int k;
		text_cut = 1'b0;
		cut_chance = 0;
		put_byte(CharQuote, 1'b1, 1'b0);
		put_byte(CharBackslash, 1'b0, 1'b0);
		put_byte(CharU, 1'b0, 1'b0);
		k = $urandom_range(3);
		repeat (k) put_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))),
			1'b0, 1'b0);
		do begin
			b = 8'($urandom_range(255));
			d = hex_digit(b);
		end while (d[4]);
		put_byte(b, 1'b0, 1'($urandom_range(1)));
	endtask

	// pause the sender until every predicted result has been taken
	task automatic wait_drained();
		text_valid <= 1'b0;
		while (expected_output.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainSlack) @(posedge clk);
	endtask

	task automatic run_text_mix(input int goal);
		int stop;
		int pick;
		stop = bytes_decoded + goal;
		while (bytes_decoded < stop) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				send_string(2, 1'b1);
			end else if (pick < 80) begin
				send_string(25, 1'b1);
			end else if (pick < 88) begin
				// left open: the next start flag abandons it
				send_string(0, 1'b0);
			end else if (pick < 94) begin
				send_bad_hex();
			end else begin
				send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
					$urandom_range(3) == 0);
			end
		end
		wait_drained();
	endtask

	task automatic test_escapes_and_unicode();
		send_byte(CharQuote, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(CharBackslash, 1'b0, 1'b0);
		send_byte(CharN, 1'b0, 1'b0);
		send_byte(CharBackslash, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(CharBackslash, 1'b0, 1'b0);
		send_byte(CharU, 1'b0, 1'b0);
		repeat (3) send_byte(hex_char(4'hF, 1'b1), 1'b0, 1'b0);
		// three UTF-8 bytes followed by a truncation
		send_byte(hex_char(4'hF, 1'b0), 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_errors_and_restart();
		send_byte(CharUpA, 1'b0, 1'b1);
		send_byte(CharBackslash, 1'b1, 1'b0);
		send_byte(CharQuote, 1'b1, 1'b0);
		send_byte(CharBackslash, 1'b0, 1'b0);
		send_byte(CharU, 1'b0, 1'b0);
		send_byte(CharSlash, 1'b0, 1'b0);
		send_byte(CharQuote, 1'b1, 1'b1);
		send_byte(CharQuote, 1'b1, 1'b0);
		send_byte(CharUpA, 1'b0, 1'b0);
		send_byte(CharQuote, 1'b1, 1'b0);
		send_byte(CharQuote, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_no_idling();
		send_pct = 0;
		recv_pct <= 0;
		run_text_mix(70);
	endtask

	task automatic test_sender_idle();
		send_pct = 50;
		recv_pct <= 0;
		run_text_mix(70);
	endtask

	task automatic test_receiver_stall();
		send_pct = 0;
		recv_pct <= 50;
		run_text_mix(70);
	endtask

	task automatic test_both_idle();
		send_pct = 29;
		recv_pct <= 29;
		run_text_mix(70);
	endtask

	task automatic test_full_buffer();
		send_pct = 0;
		recv_pct <= 0;
		hold_go <= 1'b1;
		send_byte(CharQuote, 1'b1, 1'b0);
		hold_go <= 1'b0;
		repeat (30) send_byte(CharUpA + 8'($urandom_range(25)), 1'b0, 1'b0);
		send_byte(CharQuote, 1'b0, 1'b0);
		wait_drained();
	endtask

	always @(posedge clk) begin : result_stall_gen
		int hold_left;
		if (hold_go) begin
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= MaxReports) begin
			$display("%0t: %s", $realtime, what);
		end
	endtask

	always @(posedge clk) begin : check_results
		decoded_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (expected_output.size() == 0) begin
				note_mismatch($sformatf("unexpected result: status %0d byte %02h last %0b",
					status, out_byte, last_of_run));
			end else begin
				want = expected_output.pop_front();
				if (status !== want.status || out_byte !== want.data
						|| last_of_run !== want.last) begin
					note_mismatch($sformatf(
						"expected status %0d byte %02h last %0b, got %0d %02h %0b",
						want.status, want.data, want.last, status, out_byte, last_of_run));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WatchdogLimit) begin
				$display("watchdog: no transfer in %0d cycles, %0d results outstanding",
					quiet_cycles, expected_output.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_escapes_and_unicode();
		test_errors_and_restart();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_full_buffer();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Decoded %0d text bytes into %0d checked results, %0d mismatches.",
			bytes_decoded, results_checked, mismatches);
		$display("Ran directed escapes and errors, four idle mixes and a full-buffer hold.");
		if (mismatches == 0 && expected_output.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
